@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the varispeed loop buffer RTL.
// No dependencies; the assertions drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that cons holds in the same cycle as ante.
`define VLB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Checks that cons holds in the cycle after ante.
`define VLB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VLB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define VLB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/core/vlb_pkg.sv @@
// Shared types, constants and helper functions of the varispeed loop buffer.
// No dependencies; vlb_cfg, vlb_seq and the top level import this package.
`timescale 1ns / 1ps

package vlb_pkg;

    // Field and storage widths.
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 24;
    localparam int SPEED_W = 28;
    localparam int FADE_W  = 17;
    localparam int LEN_W   = 17;
    localparam int CFG_AW  = 4;

    localparam logic [FADE_W-1:0]  ONE_Q16   = 17'h10000;
    localparam logic [LEN_W-1:0]   MAX_LEN   = 17'h10000;
    localparam logic [LEN_W-1:0]   MIN_LEN   = 17'd2;

    // Largest speed; also bounds the number of head steps per read beat.
    localparam int MAX_SPEED = 8;
    localparam int STEP_W    = $clog2(MAX_SPEED + 1);
    localparam logic [SPEED_W-1:0] MAX_SPEED_Q24 = SPEED_W'(MAX_SPEED) << FRAC_W;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_SET_RD = 2'd2,
        ACT_SET_WR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_LOOP_START = 2'd0,
        REG_LOOP_LEN   = 2'd1,
        REG_REVERSE    = 2'd2,
        REG_NARROW     = 2'd3
    } t_reg_idx;

    // Configuration as seen by the sequencer; win_len is already clamped.
    typedef struct packed {
        logic [ADDR_W-1:0] loop_start;
        logic [LEN_W-1:0]  win_len;
        logic              reverse_mode;
        logic              narrow;
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WR_RD,
        S_WR_MUL_A,
        S_WR_MUL_B,
        S_WR_BACK,
        S_RD_S0,
        S_RD_S1,
        S_RD_DIFF,
        S_RD_MUL,
        S_RD_SUM,
        S_RD_STEP,
        S_RD_DONE
    } t_state;

    // One head step inside the loop window. Backward never lands on loop_start.
    function automatic logic [ADDR_W-1:0] f_step(input logic [ADDR_W-1:0] h,
                                                 input logic              back,
                                                 input t_cfg              cfg);
        logic [ADDR_W+1:0] end_v;
        logic [ADDR_W+1:0] inc;
        logic [ADDR_W+1:0] lim;
        logic [ADDR_W-1:0] res;
        end_v = {2'b00, cfg.loop_start} + {1'b0, cfg.win_len};
        inc   = {2'b00, h} + (ADDR_W+2)'(1);
        lim   = {2'b00, cfg.loop_start} + (ADDR_W+2)'(1);
        if (!back) begin
            res = (inc >= end_v) ? cfg.loop_start : inc[ADDR_W-1:0];
        end else begin
            if ({2'b00, h} <= lim) begin
                res = end_v[ADDR_W-1:0] - ADDR_W'(1);
            end else begin
                res = h - ADDR_W'(1);
            end
        end
        return res;
    endfunction

    // Stored word to sample value, honoring the narrow sample mode.
    function automatic logic signed [DATA_W-1:0] f_load(input logic [DATA_W-1:0] w,
                                                        input logic              narrow);
        logic signed [DATA_W-1:0] v;
        v = narrow ? {{(DATA_W-16){w[15]}}, w[15:0]} : w;
        return v;
    endfunction

endpackage

@@ rtl/core/vlb_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module vlb_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/vlb_cfg.sv @@
// APB-style configuration registers of the varispeed loop buffer.
// Depends on vlb_pkg for register indexes and the configuration struct.
`timescale 1ns / 1ps

module vlb_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vlb_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output vlb_pkg::t_cfg              o_cfg
);
    import vlb_pkg::*;

    logic [ADDR_W-1:0] r_loop_start;
    logic [LEN_W-1:0]  r_loop_len;
    logic              r_reverse;
    logic              r_narrow;
    logic              wr_en;
    t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    // Register writes on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_start <= '0;
            r_loop_len   <= MAX_LEN;
            r_reverse    <= 1'b0;
            r_narrow     <= 1'b1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_LOOP_START: r_loop_start <= pwdata[ADDR_W-1:0];
                REG_LOOP_LEN:   r_loop_len   <= pwdata[LEN_W-1:0];
                REG_REVERSE:    r_reverse    <= pwdata[0];
                REG_NARROW:     r_narrow     <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back the raw register values.
    always_comb begin
        case (reg_idx)
            REG_LOOP_START: prdata = {{(32-ADDR_W){1'b0}}, r_loop_start};
            REG_LOOP_LEN:   prdata = {{(32-LEN_W){1'b0}}, r_loop_len};
            REG_REVERSE:    prdata = {31'd0, r_reverse};
            REG_NARROW:     prdata = {31'd0, r_narrow};
            default:        prdata = '0;
        endcase
    end

    // Clamp the loop length into its legal window.
    always_comb begin
        o_cfg.loop_start   = r_loop_start;
        o_cfg.reverse_mode = r_reverse;
        o_cfg.narrow       = r_narrow;
        if (r_loop_len < MIN_LEN) begin
            o_cfg.win_len = MIN_LEN;
        end else if (r_loop_len > MAX_LEN) begin
            o_cfg.win_len = MAX_LEN;
        end else begin
            o_cfg.win_len = r_loop_len;
        end
    end

endmodule

@@ rtl/core/vlb_seq.sv @@
// Sequencer and datapath: clears the store, sets heads, crossfades writes, interpolates reads.
// Depends on vlb_pkg and assert_macros.svh; drives the sample RAM ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vlb_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vlb_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic signed [31:0]          i_sample_in,
    input  logic [vlb_pkg::FADE_W-1:0]  i_fade_q16,
    input  logic [vlb_pkg::SPEED_W-1:0] i_speed_q24,
    input  logic                        i_reverse_step,
    input  logic [vlb_pkg::ADDR_W-1:0]  i_other_head,
    input  logic [vlb_pkg::ADDR_W-1:0]  i_position,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_sample_out,
    output logic                        o_head_landed,
    output logic                        o_ram_we,
    output logic [vlb_pkg::ADDR_W-1:0]  o_ram_waddr,
    output logic [vlb_pkg::DATA_W-1:0]  o_ram_wdata,
    output logic [vlb_pkg::ADDR_W-1:0]  o_ram_raddr,
    input  logic [vlb_pkg::DATA_W-1:0]  i_ram_rdata
);
    import vlb_pkg::*;

    // Control state.
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ADDR_W-1:0]   r_rd_head;
    logic [ADDR_W-1:0]   r_wr_head;
    logic [FRAC_W-1:0]   r_frac;
    logic [STEP_W-1:0]   r_steps;
    logic                r_out_valid;

    // Beat payload and datapath registers.
    t_action                  r_action;
    logic signed [DATA_W-1:0] r_sample;
    logic [FADE_W-1:0]        r_fade;
    logic [SPEED_W-1:0]       r_speed;
    logic                     r_back;
    logic [ADDR_W-1:0]        r_other;
    logic signed [DATA_W-1:0] r_old;
    logic signed [49:0]       r_prod_a;
    logic signed [49:0]       r_prod_b;
    logic signed [DATA_W-1:0] r_s0;
    logic signed [DATA_W:0]   r_diff;
    logic signed [57:0]       r_rprod;
    logic signed [DATA_W-1:0] r_res;
    logic                     r_cross;
    logic signed [DATA_W-1:0] r_out_sample;
    logic                     r_out_cross;

    logic                     in_acc;
    logic                     out_free;
    logic signed [DATA_W-1:0] rd_val;
    logic signed [50:0]       mix_sum;
    logic signed [50:0]       mix_rnd;
    logic [DATA_W-1:0]        mix_word;
    logic [ADDR_W-1:0]        rd_next;
    logic [ADDR_W-1:0]        wr_next;
    logic [SPEED_W-1:0]       speed_sat;
    logic [SPEED_W-1:0]       frac_sum;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_val   = f_load(i_ram_rdata, i_cfg.narrow);
    assign rd_next  = f_step(r_rd_head, r_back, i_cfg);
    assign wr_next  = f_step(r_wr_head, r_back, i_cfg);

    // Crossfade sum, truncated toward zero, then narrowed if needed.
    assign mix_sum  = {r_prod_a[49], r_prod_a} + {r_prod_b[49], r_prod_b};
    assign mix_rnd  = mix_sum + (mix_sum[50] ? 51'sd65535 : 51'sd0);
    always_comb begin
        mix_word = mix_rnd[47:16];
        if (i_cfg.narrow) begin
            mix_word = {{(DATA_W-16){mix_rnd[31]}}, mix_rnd[31:16]};
        end
    end

    // Speed saturation and fraction advance.
    assign speed_sat = (r_speed > MAX_SPEED_Q24) ? MAX_SPEED_Q24 : r_speed;
    assign frac_sum  = {{(SPEED_W-FRAC_W){1'b0}}, r_frac} + speed_sat;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_clr_addr == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    case (t_action'(i_action))
                        ACT_WRITE: n_state = S_WR_RD;
                        ACT_READ:  n_state = S_RD_S0;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_WR_RD:    n_state = S_WR_MUL_A;
            S_WR_MUL_A: n_state = S_WR_MUL_B;
            S_WR_MUL_B: n_state = S_WR_BACK;
            S_WR_BACK:  n_state = S_IDLE;
            S_RD_S0:    n_state = S_RD_S1;
            S_RD_S1:    n_state = S_RD_DIFF;
            S_RD_DIFF:  n_state = S_RD_MUL;
            S_RD_MUL:   n_state = S_RD_SUM;
            S_RD_SUM:   n_state = S_RD_STEP;
            S_RD_STEP:  if (r_steps == '0) n_state = S_RD_DONE;
            S_RD_DONE:  if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Memory port and handshake outputs.
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_ram_we    = 1'b0;
        o_ram_waddr = r_wr_head;
        o_ram_wdata = mix_word;
        o_ram_raddr = r_rd_head;
        case (r_state)
            S_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_clr_addr;
                o_ram_wdata = '0;
            end
            S_WR_RD:   o_ram_raddr = r_wr_head;
            S_WR_BACK: o_ram_we    = 1'b1;
            S_RD_S1:   o_ram_raddr = rd_next;
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rd_head   <= '0;
            r_wr_head   <= '0;
            r_frac      <= '0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (in_acc && t_action'(i_action) == ACT_SET_RD) begin
                r_rd_head <= i_position;
            end
            if (in_acc && t_action'(i_action) == ACT_SET_WR) begin
                r_wr_head <= i_position;
            end
            if (r_state == S_WR_BACK) begin
                r_wr_head <= wr_next;
            end
            if (r_state == S_RD_SUM) begin
                r_frac  <= frac_sum[FRAC_W-1:0];
                r_steps <= frac_sum[FRAC_W+STEP_W-1:FRAC_W];
            end
            if (r_state == S_RD_STEP && r_steps != '0) begin
                r_rd_head <= rd_next;
                r_steps   <= r_steps - STEP_W'(1);
            end
            if (r_state == S_RD_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= t_action'(i_action);
            r_sample <= i_sample_in;
            r_fade   <= i_fade_q16[FADE_W-1] ? ONE_Q16 : i_fade_q16;
            r_speed  <= i_speed_q24;
            r_back   <= i_cfg.reverse_mode ^ i_reverse_step;
            r_other  <= i_other_head;
        end
        case (r_state)
            S_WR_MUL_A: begin
                r_old    <= rd_val;
                r_prod_a <= r_sample * $signed({1'b0, r_fade});
            end
            S_WR_MUL_B: r_prod_b <= r_old * $signed({1'b0, ONE_Q16 - r_fade});
            S_RD_S1:    r_s0     <= rd_val;
            S_RD_DIFF:  r_diff   <= {rd_val[DATA_W-1], rd_val} - {r_s0[DATA_W-1], r_s0};
            S_RD_MUL:   r_rprod  <= r_diff * $signed({1'b0, r_frac});
            S_RD_SUM: begin
                r_res   <= r_s0 + r_rprod[FRAC_W+DATA_W-1:FRAC_W];
                r_cross <= 1'b0;
            end
            S_RD_STEP: begin
                if (r_steps != '0 && rd_next == r_other) begin
                    r_cross <= 1'b1;
                end
            end
            S_RD_DONE: begin
                if (out_free) begin
                    r_out_sample <= r_res;
                    r_out_cross  <= r_cross;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample_out  = r_out_sample;
    assign o_head_landed = r_out_cross;

    // The read path only runs for read beats.
    `VLB_ASSERT_IMP(a_read_path, i_clk, i_rst_n, r_state == S_RD_SUM, r_action == ACT_READ, "read path entered for a non-read beat")
    // Steps per read beat never exceed the speed limit.
    `VLB_ASSERT_IMP(a_step_bound, i_clk, i_rst_n, 1'b1, r_steps <= STEP_W'(MAX_SPEED), "step count above speed limit")
    // Each stepping cycle consumes exactly one step.
    `VLB_ASSERT_NXT(a_step_dec, i_clk, i_rst_n, r_state == S_RD_STEP && r_steps != '0, r_steps == STEP_W'($past(r_steps) - STEP_W'(1)), "step count did not decrement")
    // The store is written only by the clearing pass and write-back.
    `VLB_ASSERT_IMP(a_ram_write, i_clk, i_rst_n, o_ram_we, r_state == S_CLEAR || r_state == S_WR_BACK, "unexpected store write")

endmodule

@@ rtl/core/varispeed_loop_buffer_top.sv @@
// Varispeed loop buffer: a 64K x 32 looping sample store with a read and a write head.
// After reset a clearing pass zeroes the store, during which no input beat is taken
// (configuration writes still are). Each input beat then runs through a sequencer
// around one RAM with a registered read port: a head set is applied as the beat is
// taken, a crossfaded write reads the old word, does two multiplies and writes back,
// and a read fetches its two samples in turn through the shared RAM read port,
// interpolates, and then steps the head one slot per cycle for each whole slot it
// advances (0 to 8, set by the speed). A read beat yields one result beat; the next
// input beat is taken while that result waits in the output register.
// Depends on vlb_pkg, vlb_cfg, vlb_ram and vlb_seq.
`timescale 1ns / 1ps

module varispeed_loop_buffer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vlb_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic signed [31:0]          i_sample_in,
    input  logic [vlb_pkg::FADE_W-1:0]  i_fade_q16,
    input  logic [vlb_pkg::SPEED_W-1:0] i_speed_q24,
    input  logic                        i_reverse_step,
    input  logic [vlb_pkg::ADDR_W-1:0]  i_other_head,
    input  logic [vlb_pkg::ADDR_W-1:0]  i_position,
    // Output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_sample_out,
    output logic                        o_head_landed
);
    import vlb_pkg::*;

    t_cfg              cfg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Configuration registers.
    vlb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sample store.
    vlb_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer and arithmetic.
    vlb_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_sample_in     (i_sample_in),
        .i_fade_q16      (i_fade_q16),
        .i_speed_q24     (i_speed_q24),
        .i_reverse_step  (i_reverse_step),
        .i_other_head    (i_other_head),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sample_out    (o_sample_out),
        .o_head_landed   (o_head_landed),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking bench for varispeed_loop_buffer_top: beats go in through a queue-fed driver,
// and every read result is compared with a cycle-free predictor of the loop store and heads.
// Depends on vlb_pkg and the varispeed_loop_buffer_top RTL.
`timescale 1ns / 1ps

module tb_top;
    import vlb_pkg::*;

    // One input beat as the driver presents it.
    typedef struct packed {
        t_action                    action;
        logic signed [DATA_W-1:0]   sample;
        logic [FADE_W-1:0]          fade;
        logic [SPEED_W-1:0]         speed;
        logic                       rev;
        logic [ADDR_W-1:0]          other;
        logic [ADDR_W-1:0]          pos;
    } stim_beat_t;

    // One read result as the block should deliver it.
    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              crossed;
    } interp_result_t;

    localparam longint ONE_Q24_L   = longint'(1) << FRAC_W;
    localparam longint SPEED_CAP_L = longint'(MAX_SPEED) << FRAC_W;
    localparam int     SETTLE_CYC  = 40;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    // Configuration port signals.
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Stream signals.
    logic              in_valid  = 1'b0;
    logic              in_stall;
    stim_beat_t        cur_beat  = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic signed [31:0] out_sample;
    logic              out_crossed;

    // Predictor state: store, heads, fraction and configuration shadow.
    logic [DATA_W-1:0]  pcm_store [0:65535];
    logic [ADDR_W-1:0]  rd_head = '0;
    logic [ADDR_W-1:0]  wr_head = '0;
    logic [FRAC_W-1:0]  rd_frac = '0;
    logic [ADDR_W-1:0]  cfg_start  = '0;
    logic [LEN_W-1:0]   cfg_len    = MAX_LEN;
    logic               cfg_rev    = 1'b0;
    logic               cfg_narrow = 1'b1;

    stim_beat_t      beat_backlog [$];
    interp_result_t  interp_due [$];
    int unsigned     beats_queued = 0;
    int unsigned     bad_fields   = 0;
    int unsigned     gap_left     = 0;
    int unsigned     burst_left   = 1;
    int unsigned     stall_tick   = 0;
    int unsigned     stall_mode   = 0;

    always #5 i_clk = ~i_clk;

    varispeed_loop_buffer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_action        (cur_beat.action),
        .i_sample_in     (cur_beat.sample),
        .i_fade_q16      (cur_beat.fade),
        .i_speed_q24     (cur_beat.speed),
        .i_reverse_step  (cur_beat.rev),
        .i_other_head    (cur_beat.other),
        .i_position      (cur_beat.pos),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_sample_out    (out_sample),
        .o_head_landed   (out_crossed)
    );

    // Loop length as the block uses it, clamped to 2..65536.
    function automatic int unsigned window_span();
        if (cfg_len < MIN_LEN) return 2;
        if (cfg_len > MAX_LEN) return 65536;
        return int'(cfg_len);
    endfunction

    // One head step with wrap inside the loop window.
    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] h,
                                                    input logic back);
        int unsigned last;
        int unsigned hv;
        int unsigned n;
        last = int'(cfg_start) + window_span();
        hv   = int'(h);
        if (!back) begin
            n = hv + 1;
            if (n >= last) n = int'(cfg_start);
        end else begin
            if (hv <= int'(cfg_start) + 1) n = last - 1;
            else n = hv - 1;
        end
        return ADDR_W'(n);
    endfunction

    // Stored word read back as a sample, honoring narrow mode.
    function automatic longint sample_at(input logic [ADDR_W-1:0] h);
        logic [DATA_W-1:0] w;
        w = pcm_store[h];
        if (cfg_narrow) return longint'($signed(w[15:0]));
        return longint'($signed(w));
    endfunction

    // Applies one accepted beat to the predictor and queues any read result.
    function automatic void step_loop_store(input stim_beat_t b);
        logic           back;
        longint         s_new, f, old, mix, frac, spd, s0, s1, p, q;
        logic           hit;
        interp_result_t r;
        back = cfg_rev ^ b.rev;
        case (b.action)
            ACT_WRITE: begin
                s_new = longint'(b.sample);
                f     = (b.fade > ONE_Q16) ? 65536 : longint'(b.fade);
                old   = sample_at(wr_head);
                mix   = (s_new * f + old * (65536 - f)) / 65536;
                pcm_store[wr_head] = cfg_narrow ? {{16{mix[15]}}, mix[15:0]} : mix[31:0];
                wr_head = next_slot(wr_head, back);
            end
            ACT_SET_RD: rd_head = b.pos;
            ACT_SET_WR: wr_head = b.pos;
            default: begin
                frac = longint'(rd_frac);
                s0   = sample_at(rd_head);
                s1   = sample_at(next_slot(rd_head, back));
                p    = (s1 - s0) * frac;
                q    = p >>> FRAC_W;
                spd  = longint'(b.speed);
                if (spd > SPEED_CAP_L) spd = SPEED_CAP_L;
                frac = frac + spd;
                hit  = 1'b0;
                while (frac >= ONE_Q24_L) begin
                    frac    = frac - ONE_Q24_L;
                    rd_head = next_slot(rd_head, back);
                    if (rd_head == b.other) hit = 1'b1;
                end
                rd_frac   = frac[FRAC_W-1:0];
                r.sample  = DATA_W'(s0 + q);
                r.crossed = hit;
                interp_due.push_back(r);
            end
        endcase
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %s: got %h want %h", what, got, want);
        bad_fields++;
    endtask

    // Input driver: bursts of beats with random gaps, payload held while stalled.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                step_loop_store(cur_beat);
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (beat_backlog.size() > 0) begin
                    cur_beat <= beat_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 18);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted result beat, then picks the next stall.
    always @(posedge i_clk) begin
        interp_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (interp_due.size() == 0) begin
                report_mismatch("result beat with none due", out_sample, '0);
            end else begin
                want = interp_due.pop_front();
                if (out_sample !== want.sample)
                    report_mismatch("sample_out", out_sample, want.sample);
                if (out_crossed !== want.crossed)
                    report_mismatch("head_landed", 32'(out_crossed), 32'(want.crossed));
            end
        end
        stall_tick++;
        if (stall_tick[7:0] == 8'd0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= (stall_tick[3:0] < 4'd12);
        endcase
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LOOP_START: cfg_start  = val[ADDR_W-1:0];
            REG_LOOP_LEN:   cfg_len    = val[LEN_W-1:0];
            REG_REVERSE:    cfg_rev    = val[0];
            default:        cfg_narrow = val[0];
        endcase
    endtask

    task automatic apply_config(input logic [31:0] start, input logic [31:0] len,
                                input logic rev, input logic narrow);
        write_reg(REG_LOOP_START, start);
        write_reg(REG_LOOP_LEN, len);
        write_reg(REG_REVERSE, 32'(rev));
        write_reg(REG_NARROW, 32'(narrow));
    endtask

    // Waits until every beat is in and every result out, then lets the block settle.
    task automatic drain();
        while (beat_backlog.size() != 0 || in_valid || interp_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic push_beat(input t_action act, input logic [31:0] sample,
                             input logic [FADE_W-1:0] fade, input logic [SPEED_W-1:0] speed,
                             input logic rev, input logic [ADDR_W-1:0] other,
                             input logic [ADDR_W-1:0] pos);
        stim_beat_t b;
        b.action = act;
        b.sample = sample;
        b.fade   = fade;
        b.speed  = speed;
        b.rev    = rev;
        b.other  = other;
        b.pos    = pos;
        beat_backlog.push_back(b);
        beats_queued++;
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1:       return 32'($urandom_range(0, 65535)) - 32'd32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [FADE_W-1:0] pick_fade();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FADE_W'($urandom_range(65537, 131071));
            2, 3:    return FADE_W'($urandom_range(0, 65536));
            default: return ONE_Q16;
        endcase
    endfunction

    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 19))
            0:          return '0;
            1, 2:       return SPEED_W'($urandom);
            3, 4, 5, 6: return SPEED_W'(32'd1 << FRAC_W);
            7, 8, 9, 10, 11: return SPEED_W'($urandom_range(0, 32'h0800_0000));
            default:    return SPEED_W'($urandom_range(0, 32'h0100_0000));
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] in_window();
        return ADDR_W'(int'(cfg_start) + $urandom_range(0, window_span() - 1));
    endfunction

    // A write run followed by a read run, mostly over the same stretch of the window.
    task automatic queue_phrase();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] oth;
        int unsigned       n;
        base = in_window();
        push_beat(ACT_SET_WR, $urandom, pick_fade(), SPEED_W'($urandom),
                  1'($urandom_range(0, 1)), ADDR_W'($urandom), base);
        n = $urandom_range(2, 16);
        repeat (n) begin
            push_beat(ACT_WRITE, pick_sample(), pick_fade(), SPEED_W'($urandom),
                      ($urandom_range(0, 7) == 0), ADDR_W'($urandom), ADDR_W'($urandom));
        end
        base = ($urandom_range(0, 3) == 0) ? in_window() : base;
        push_beat(ACT_SET_RD, $urandom, pick_fade(), SPEED_W'($urandom),
                  1'($urandom_range(0, 1)), ADDR_W'($urandom), base);
        n = $urandom_range(2, 16);
        repeat (n) begin
            oth = $urandom_range(0, 1) ? ADDR_W'(base + $urandom_range(0, 10)) : in_window();
            push_beat(ACT_READ, $urandom, pick_fade(), pick_speed(),
                      ($urandom_range(0, 7) == 0), oth, ADDR_W'($urandom));
        end
    endtask

    // Short directed run over a tiny window at 100..107 with 32-bit samples.
    task automatic queue_directed();
        push_beat(ACT_SET_WR, 0, 0, 0, 0, 0, 16'd100);
        push_beat(ACT_WRITE, 32'h7FFF_FFFF, ONE_Q16, 0, 0, 0, 0);
        push_beat(ACT_WRITE, 32'h8000_0000, ONE_Q16, 0, 0, 0, 0);
        // Zero fade keeps the old word.
        push_beat(ACT_WRITE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        // Fade above one acts as a plain write.
        push_beat(ACT_WRITE, 32'd12345, 17'h1FFFF, 0, 0, 0, 0);
        push_beat(ACT_WRITE, 32'h5555_5555, 17'h08000, 0, 0, 0, 0);
        push_beat(ACT_WRITE, 32'hC000_0000, 17'd1, 0, 0, 0, 0);
        push_beat(ACT_WRITE, 32'h0001_0000, 17'h0FFFF, 0, 0, 0, 0);
        push_beat(ACT_WRITE, 32'h7FFF_8000, ONE_Q16, 0, 0, 0, 0);
        // Write head has wrapped to the start; crossfade with the first sample.
        push_beat(ACT_WRITE, 32'h4000_0000, 17'h08000, 0, 0, 0, 0);
        // Backward from the slot after the start jumps to the last slot.
        push_beat(ACT_WRITE, 32'd1, ONE_Q16, 0, 1'b1, 0, 0);
        push_beat(ACT_SET_RD, 0, 0, 0, 0, 0, 16'd100);
        push_beat(ACT_READ, 0, 0, 28'd0, 0, 16'd100, 0);
        push_beat(ACT_READ, 0, 0, 28'h080_0000, 0, 16'd100, 0);
        push_beat(ACT_READ, 0, 0, 28'h080_0000, 0, 16'd101, 0);
        push_beat(ACT_READ, 0, 0, 28'h100_0000, 0, 16'd102, 0);
        push_beat(ACT_READ, 0, 0, 28'h080_0000 | 28'h800_0000, 0, 16'd105, 0);
        // Speed above the maximum saturates.
        push_beat(ACT_READ, 0, 0, 28'hFFF_FFFF, 0, 16'd0, 0);
        push_beat(ACT_READ, 0, 0, 28'h0C0_0000, 1'b1, 16'd107, 0);
        // Head outside the window steps forward to the start.
        push_beat(ACT_SET_RD, 0, 0, 0, 0, 0, 16'hFFFF);
        push_beat(ACT_READ, 0, 0, 28'h100_0000, 0, 16'd100, 0);
        // Backward from the start goes to the last slot.
        push_beat(ACT_SET_RD, 0, 0, 0, 0, 0, 16'd100);
        push_beat(ACT_READ, 0, 0, 28'h100_0000, 1'b1, 16'd107, 0);
        push_beat(ACT_SET_WR, 0, 0, 0, 0, 0, 16'hFFFF);
        push_beat(ACT_WRITE, 32'hDEAD_BEEF, ONE_Q16, 0, 0, 0, 0);
        push_beat(ACT_READ, 0, 0, 28'h0FF_FFFF, 0, 16'hFFFF, 0);
    endtask

    // Main sequence: reset, directed run, then random phases over several settings.
    initial begin
        int unsigned target;
        for (int k = 0; k < 65536; k++) pcm_store[k] = '0;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        apply_config(32'd100, 32'd8, 1'b0, 1'b0);
        @(negedge i_clk);
        queue_directed();
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0:       apply_config(32'd0, 32'd65536, 1'b0, 1'b1);
                1:       apply_config(32'd65535, 32'd65536, 1'b1, 1'b0);
                2:       apply_config(32'd1000, 32'd0, 1'b0, 1'b0);
                3:       apply_config(32'd40000, 32'd1, 1'b1, 1'b1);
                4:       apply_config(32'd65520, 32'h1FFFF, 1'b0, 1'b0);
                5:       apply_config(32'd0, 32'd2, 1'b1, 1'b1);
                6:       apply_config(32'd65534, 32'd17, 1'b0, 1'b1);
                default: apply_config($urandom_range(0, 65535), $urandom_range(2, 48),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            @(negedge i_clk);
            target = beats_queued + 128;
            while (beats_queued < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise beat with every field random.
                    push_beat(t_action'($urandom_range(0, 3)), $urandom,
                              FADE_W'($urandom), SPEED_W'($urandom),
                              1'($urandom_range(0, 1)),
                              ADDR_W'($urandom), ADDR_W'($urandom));
                end else begin
                    queue_phrase();
                end
            end
            drain();
        end

        if (bad_fields == 0) begin
            $display("varispeed_loop_buffer_top: match");
        end else begin
            $display("varispeed_loop_buffer_top: mismatch");
        end
        $finish;
    end

    // Run limit, well beyond the clearing pass plus the slowest correct run.
    initial begin
        #8_000_000;
        $display("varispeed_loop_buffer_top: mismatch");
        $finish;
    end

endmodule
